// ----- rtl/lrsd_pkg.sv -----
`default_nettype none
package lrsd_pkg;

	// Status codes reported with every result beat.
	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// Per-tick control handed from the parser to the history stage.
	typedef struct packed {
		logic       taken;
		logic       ov;
		logic       copy;
		logic [7:0] lit;
		logic [1:0] status;
	} lrsd_tick_t;

endpackage
`default_nettype wire

// ----- rtl/lrsd_in_if.sv -----
`default_nettype none
interface lrsd_in_if;
	logic       valid;
	logic       ready;
	logic       in_valid;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_valid, in_byte, in_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/lrsd_out_if.sv -----
`default_nettype none
interface lrsd_out_if;
	logic       valid;
	logic       ready;
	logic       byte_taken;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [1:0] status;

	modport source (output valid, byte_taken, out_valid, out_byte, status, input ready);
	modport sink   (input valid, byte_taken, out_valid, out_byte, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/lrsd_parse.sv -----
`default_nettype none
module lrsd_parse #(
	parameter int WINDOW_DEPTH = 8192,
	parameter int AW = $clog2(WINDOW_DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic              in_valid,
	input  wire logic [7:0]        in_byte,
	input  wire logic              in_last,
	output lrsd_pkg::lrsd_tick_t   tick,
	output logic [AW-1:0]          waddr,
	output logic [AW-1:0]          raddr
);
	import lrsd_pkg::*;

	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [AW-1:0] LAST_WP = AW'(WINDOW_DEPTH - 1);
	localparam logic [AW:0] DEPTH_X = (AW+1)'(WINDOW_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

	typedef enum logic [30:0] {
		PH_H0     = 31'b1 << 0,
		PH_H1     = 31'b1 << 1,
		PH_H2     = 31'b1 << 2,
		PH_H3     = 31'b1 << 3,
		PH_SKIP   = 31'b1 << 4,
		PH_BTOK   = 31'b1 << 5,
		PH_BAFTER = 31'b1 << 6,
		PH_BLITLEN= 31'b1 << 7,
		PH_BLIT   = 31'b1 << 8,
		PH_BRLELEN= 31'b1 << 9,
		PH_BRLEB  = 31'b1 << 10,
		PH_BOFF   = 31'b1 << 11,
		PH_BSZ0   = 31'b1 << 12,
		PH_BSZ1   = 31'b1 << 13,
		PH_T0     = 31'b1 << 14,
		PH_T1     = 31'b1 << 15,
		PH_OFFB   = 31'b1 << 16,
		PH_OFFHI  = 31'b1 << 17,
		PH_OFFLO  = 31'b1 << 18,
		PH_RFLAG  = 31'b1 << 19,
		PH_RLEN   = 31'b1 << 20,
		PH_RLENB  = 31'b1 << 21,
		PH_RBYTE  = 31'b1 << 22,
		PH_MARK   = 31'b1 << 23,
		PH_LEN    = 31'b1 << 24,
		PH_LENB   = 31'b1 << 25,
		PH_LEN3   = 31'b1 << 26,
		PH_FILL   = 31'b1 << 27,
		PH_COPY   = 31'b1 << 28,
		PH_DONE   = 31'b1 << 29,
		PH_BAD    = 31'b1 << 30
	} phase_t;

	typedef struct packed {
		phase_t      ph;
		logic [13:0] pl;
		logic [12:0] cd;
		logic [15:0] left;
	} tok_t;

	// Decodes a byte-format token, or a block marker when the block is used up.
	function automatic tok_t byte_tok(input logic [7:0] b, input logic [15:0] left,
			input logic [13:0] pl, input logic [12:0] cd);
		tok_t r;
		r.ph = PH_BAD;
		r.pl = pl;
		r.cd = cd;
		r.left = left;
		if (left == 16'd0) begin
			r.ph = (b == 8'd0) ? PH_DONE : PH_BSZ0;
		end else begin
			r.left = left - 16'd1;
			if (!b[7]) begin
				if (!b[6]) begin
					r.pl = {9'd0, b[4:0]};
					r.ph = b[5] ? PH_BLITLEN : ((b[4:0] != 5'd0) ? PH_BLIT : PH_BAD);
				end else if (b[4]) begin
					r.pl = {8'd0, b[5], 1'b0, b[3:0]};
					r.ph = PH_BRLELEN;
				end else begin
					r.pl = {8'd0, b[5], 1'b0, b[3:0]} + 14'd4;
					r.ph = PH_BRLEB;
				end
			end else begin
				r.pl = 14'(b[6:5]) + 14'd4;
				r.cd = {b[4:0], 8'd0};
				r.ph = PH_BOFF;
			end
		end
		return r;
	endfunction

	phase_t        ph_q, n_ph;
	logic          fmt_q, n_fmt;
	logic [15:0]   fw_q, n_fw;
	logic [4:0]    fl_q, n_fl;
	logic [13:0]   pl_q, n_pl;
	logic [12:0]   cd_q, n_cd;
	logic [7:0]    fill_q, n_fill;
	logic [15:0]   bbl_q, n_bbl;
	logic          half_q, n_half;
	logic [2:0]    bc_q, n_bc;
	logic          long_q, n_long;
	logic          drn_q, n_drn;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] pc_q;
	logic          taken, ov, cpy;
	logic [7:0]    lit;
	logic          body, marker, bitph, bit0;
	logic [AW:0]   wpx, dx;
	tok_t          t;
	logic [15:0]   nb;

	assign body   = (ph_q == PH_BLITLEN) || (ph_q == PH_BRLELEN) || (ph_q == PH_BRLEB) ||
	                (ph_q == PH_BOFF) || ((ph_q == PH_BLIT) && fmt_q);
	assign marker = ((ph_q == PH_BTOK) || (ph_q == PH_BAFTER)) && (bbl_q == 16'd0);
	assign bitph  = (ph_q == PH_T0) || (ph_q == PH_T1) || (ph_q == PH_OFFHI) ||
	                (ph_q == PH_RFLAG) || (ph_q == PH_RLEN) || (ph_q == PH_LEN) ||
	                (ph_q == PH_LEN3);
	assign bit0   = fw_q[0];

	// Copy source sits copy_distance bytes behind the write pointer, modulo the ring.
	assign wpx = {1'b0, wp_q};
	assign dx  = (AW+1)'(cd_q);
	always_comb begin
		if (wpx >= dx) begin
			raddr = AW'(wpx - dx);
		end else begin
			raddr = AW'(wpx + DEPTH_X - dx);
		end
	end
	assign waddr = wp_q;

	always_comb begin
		n_ph = ph_q; n_fmt = fmt_q; n_fw = fw_q; n_fl = fl_q; n_pl = pl_q; n_cd = cd_q;
		n_fill = fill_q; n_bbl = bbl_q; n_half = half_q; n_bc = bc_q; n_long = long_q;
		n_drn = drn_q;
		taken = 1'b0; ov = 1'b0; cpy = 1'b0; lit = fill_q;
		t = byte_tok(in_byte, bbl_q, pl_q, cd_q);
		nb = {in_byte, bbl_q[7:0]};
		if ((ph_q == PH_FILL) || (ph_q == PH_COPY)) begin
			if (pl_q != 14'd0) begin
				ov = 1'b1;
				cpy = (ph_q == PH_COPY);
				n_pl = pl_q - 14'd1;
			end
			if (n_pl == 14'd0) begin
				if (!fmt_q) begin
					n_ph = PH_T0;
				end else begin
					n_ph = (ph_q == PH_COPY) ? PH_BAFTER : PH_BTOK;
				end
			end
		end else if ((ph_q == PH_DONE) || (ph_q == PH_BAD)) begin
			n_ph = ph_q;
		end else if (bitph && (fl_q != 5'd0)) begin
			n_fw = {1'b0, fw_q[15:1]};
			n_fl = fl_q - 5'd1;
			unique case (ph_q)
				PH_T0: begin
					if (bit0) begin
						n_ph = PH_T1;
					end else begin
						n_pl = 14'd1;
						n_ph = PH_BLIT;
					end
				end
				PH_T1: begin
					if (bit0) begin
						n_cd = 13'd0;
						n_bc = 3'd5;
						n_ph = PH_OFFHI;
					end else begin
						n_ph = PH_OFFB;
					end
				end
				PH_OFFHI: begin
					n_cd = {8'd0, cd_q[3:0], bit0};
					n_bc = bc_q - 3'd1;
					if (n_bc == 3'd0) n_ph = PH_OFFLO;
				end
				PH_RFLAG: begin
					n_long = bit0;
					n_pl = 14'd0;
					n_bc = 3'd4;
					n_ph = PH_RLEN;
				end
				PH_RLEN: begin
					n_pl = {10'd0, pl_q[2:0], bit0};
					n_bc = bc_q - 3'd1;
					if (n_bc == 3'd0) begin
						if (long_q) begin
							n_ph = PH_RLENB;
						end else begin
							n_pl = n_pl + 14'd14;
							n_ph = PH_RBYTE;
						end
					end
				end
				PH_LEN: begin
					if (pl_q >= 14'd6) begin
						if (bit0) begin
							n_pl = 14'd0;
							n_bc = 3'd3;
							n_ph = PH_LEN3;
						end else begin
							n_ph = PH_LENB;
						end
					end else if (bit0) begin
						n_ph = ({{(CW-13){1'b0}}, cd_q} > pc_q) ? PH_BAD : PH_COPY;
					end else begin
						n_pl = pl_q + 14'd1;
					end
				end
				default: begin
					n_pl = {11'd0, pl_q[1:0], bit0};
					n_bc = bc_q - 3'd1;
					if (n_bc == 3'd0) begin
						n_pl = n_pl + 14'd6;
						n_ph = ({{(CW-13){1'b0}}, cd_q} > pc_q) ? PH_BAD : PH_COPY;
					end
				end
			endcase
		end else if (marker && drn_q) begin
			n_ph = PH_DONE;
		end else if (body && (bbl_q == 16'd0)) begin
			n_ph = PH_BAD;
		end else if (drn_q) begin
			n_ph = PH_BAD;
		end else if (in_valid) begin
			taken = 1'b1;
			if (in_last) n_drn = 1'b1;
			if (bitph) begin
				if (!half_q) begin
					n_fw = {8'd0, in_byte};
					n_half = 1'b1;
				end else begin
					n_fw = {in_byte, fw_q[7:0]};
					n_fl = 5'd16;
					n_half = 1'b0;
				end
			end else begin
				unique case (ph_q)
					PH_H0: begin
						n_bbl = {8'd0, in_byte};
						n_ph = PH_H1;
					end
					PH_H1: begin
						n_bbl = nb;
						n_ph = PH_H2;
					end
					PH_H2: begin
						if (in_byte == 8'd0) begin
							n_fmt = 1'b0;
							n_ph = PH_H3;
						end else begin
							n_fmt = 1'b1;
							if (bbl_q < 16'd2) begin
								n_ph = PH_BAD;
							end else begin
								t = byte_tok(in_byte, bbl_q - 16'd2, pl_q, cd_q);
								n_ph = t.ph; n_pl = t.pl; n_cd = t.cd; n_bbl = t.left;
							end
						end
					end
					PH_H3: begin
						n_fw = {8'd0, in_byte};
						n_fl = 5'd8;
						n_half = 1'b0;
						n_ph = PH_T0;
					end
					PH_SKIP: begin
						if (pl_q != 14'd0) n_pl = pl_q - 14'd1;
						if (n_pl == 14'd0) n_ph = PH_H3;
					end
					PH_BTOK: begin
						n_ph = t.ph; n_pl = t.pl; n_cd = t.cd; n_bbl = t.left;
					end
					PH_BAFTER: begin
						if ((bbl_q != 16'd0) && (in_byte[7:5] == 3'b011)) begin
							n_bbl = bbl_q - 16'd1;
							n_pl = {9'd0, in_byte[4:0]};
							n_ph = (in_byte[4:0] != 5'd0) ? PH_COPY : PH_BAFTER;
						end else begin
							n_ph = t.ph; n_pl = t.pl; n_cd = t.cd; n_bbl = t.left;
						end
					end
					PH_BLITLEN: begin
						n_bbl = bbl_q - 16'd1;
						n_pl = {pl_q[5:0], in_byte};
						n_ph = (n_pl != 14'd0) ? PH_BLIT : PH_BAD;
					end
					PH_BLIT: begin
						if (fmt_q) n_bbl = bbl_q - 16'd1;
						ov = 1'b1;
						lit = in_byte;
						if (pl_q != 14'd0) n_pl = pl_q - 14'd1;
						if (n_pl == 14'd0) n_ph = fmt_q ? PH_BTOK : PH_T0;
					end
					PH_BRLELEN: begin
						n_bbl = bbl_q - 16'd1;
						n_pl = {pl_q[5:0], in_byte} + 14'd4;
						n_ph = PH_BRLEB;
					end
					PH_BRLEB, PH_RBYTE: begin
						if (ph_q == PH_BRLEB) n_bbl = bbl_q - 16'd1;
						n_fill = in_byte;
						n_ph = PH_FILL;
					end
					PH_BOFF: begin
						n_bbl = bbl_q - 16'd1;
						n_cd = {cd_q[12:8], in_byte};
						n_ph = ((n_cd == 13'd0) || ({{(CW-13){1'b0}}, n_cd} > pc_q)) ?
						       PH_BAD : PH_COPY;
					end
					PH_BSZ0: begin
						n_bbl = {8'd0, in_byte};
						n_ph = PH_BSZ1;
					end
					PH_BSZ1: begin
						if (nb < 16'd2) begin
							n_bbl = nb;
							n_ph = PH_BAD;
						end else begin
							n_bbl = nb - 16'd2;
							n_ph = PH_BTOK;
						end
					end
					PH_OFFB: begin
						if (in_byte == 8'd0) begin
							n_ph = PH_BAD;
						end else begin
							n_cd = {5'd0, in_byte};
							n_pl = 14'd2;
							n_ph = PH_LEN;
						end
					end
					PH_OFFLO: begin
						n_cd = {cd_q[4:0], in_byte};
						if (n_cd > 13'd1) begin
							n_pl = 14'd2;
							n_ph = PH_LEN;
						end else begin
							n_ph = (n_cd != 13'd0) ? PH_RFLAG : PH_MARK;
						end
					end
					PH_RLENB: begin
						n_pl = {pl_q[5:0], in_byte} + 14'd14;
						n_ph = PH_RBYTE;
					end
					PH_LENB: begin
						n_pl = {6'd0, in_byte} + 14'd14;
						n_ph = ({{(CW-13){1'b0}}, cd_q} > pc_q) ? PH_BAD : PH_COPY;
					end
					PH_MARK: begin
						if (in_byte == 8'd0) begin
							n_ph = PH_DONE;
						end else begin
							n_pl = 14'd3;
							n_ph = PH_SKIP;
						end
					end
					default: begin
						n_ph = ph_q;
					end
				endcase
			end
		end
	end

	always_comb begin
		tick.taken = taken;
		tick.ov = ov;
		tick.copy = cpy;
		tick.lit = lit;
		if (n_ph == PH_DONE) begin
			tick.status = ST_DONE;
		end else if (n_ph == PH_BAD) begin
			tick.status = ST_BAD;
		end else begin
			tick.status = ST_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_H0; fmt_q <= 1'b0; fw_q <= '0; fl_q <= '0; pl_q <= '0;
			cd_q <= '0; fill_q <= '0; bbl_q <= '0; half_q <= 1'b0; bc_q <= '0;
			long_q <= 1'b0; drn_q <= 1'b0; wp_q <= '0; pc_q <= '0;
		end else if (go) begin
			ph_q <= n_ph; fmt_q <= n_fmt; fw_q <= n_fw; fl_q <= n_fl; pl_q <= n_pl;
			cd_q <= n_cd; fill_q <= n_fill; bbl_q <= n_bbl; half_q <= n_half;
			bc_q <= n_bc; long_q <= n_long; drn_q <= n_drn;
			if (ov) begin
				wp_q <= (wp_q == LAST_WP) ? '0 : wp_q + AW'(1);
				if (pc_q < DEPTH_C) pc_q <= pc_q + CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_DONE |=> ph_q == PH_DONE) else $error("left end state");
	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_BAD |=> ph_q == PH_BAD) else $error("left error state");
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= DEPTH_C) else $error("produced count past window");
	a_no_take_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		go && ((ph_q == PH_FILL) || (ph_q == PH_COPY)) |-> !taken)
		else $error("byte taken while emitting a run");
`endif
endmodule
`default_nettype wire

// ----- rtl/lrsd_hist.sv -----
`default_nettype none
module lrsd_hist #(
	parameter int WINDOW_DEPTH = 8192,
	parameter int AW = $clog2(WINDOW_DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  lrsd_pkg::lrsd_tick_t tick,
	input  wire logic [AW-1:0]   waddr,
	input  wire logic [AW-1:0]   raddr,
	output logic                 adv,
	lrsd_out_if.source           out_ch
);
	import lrsd_pkg::*;

	logic [7:0]    mem [WINDOW_DEPTH];
	logic [7:0]    rdata_q;
	logic [7:0]    last_q;
	logic          valid_s1;
	logic          new_s1;
	logic          fwd_s1;
	lrsd_tick_t    tick_s1;
	logic [AW-1:0] waddr_s1;
	logic [7:0]    wval;
	logic          wen;
	logic          fwd;

	assign adv  = !valid_s1 || out_ch.ready;
	assign wen  = new_s1 && tick_s1.ov;
	assign wval = tick_s1.copy ? (fwd_s1 ? last_q : rdata_q) : tick_s1.lit;
	// The entry written this cycle is not yet visible to a read issued now.
	assign fwd  = wen && tick.copy && (waddr_s1 == raddr);

	always_ff @(posedge clk) begin
		if (go && tick.copy) begin
			rdata_q <= mem[raddr];
		end
		if (wen) begin
			mem[waddr_s1] <= wval;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			last_q <= wval;
		end
		if (go) begin
			tick_s1 <= tick;
			waddr_s1 <= waddr;
			fwd_s1 <= fwd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			new_s1 <= 1'b0;
		end else begin
			new_s1 <= go;
			if (go) begin
				valid_s1 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = valid_s1;
	assign out_ch.byte_taken = tick_s1.taken;
	assign out_ch.out_valid  = tick_s1.ov;
	assign out_ch.out_byte   = tick_s1.ov ? wval : 8'd0;
	assign out_ch.status     = tick_s1.status;

`ifndef SYNTHESIS
	a_fwd_copy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> tick_s1.copy && tick_s1.ov)
		else $error("forward flagged on a non-copy beat");
	a_new_valid: assert property (@(posedge clk) disable iff (!arst_n)
		new_s1 |-> valid_s1) else $error("write slot without a held beat");
	a_go_adv: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> adv) else $error("beat taken while output stage blocked");
`endif
endmodule
`default_nettype wire

// ----- rtl/lzss_rle_stream_decoder.sv -----
`default_nettype none
// LZSS/RLE stream decoder with a ring history of WINDOW_DEPTH bytes.
// in_ch carries one beat per decoder tick: in_valid says a compressed byte is
// offered, in_byte holds it and in_last marks the final compressed byte.
// out_ch returns exactly one beat per in_ch beat: byte_taken tells the source
// whether the offered byte was consumed (otherwise it offers it again on a
// later beat), out_valid/out_byte carry at most one decompressed byte, and
// status reads 0 while running, 1 at the end marker, 2 on a malformed stream.
// A beat is accepted every cycle unless out_ch stalls; its result appears on
// out_ch in the next cycle, covering the history RAM read used for copies;
// a copy one byte back is served by forwarding the byte being written.
// The result sits in an output register, so a new beat is taken in the same
// cycle the previous result is taken. When out_ch stalls, in_ch.ready drops
// and both the parser state and the held result stay put.
// Reset clears the parser to the first header byte and empties the output
// stage at once; the history RAM is not cleared, since no copy may reach
// bytes that were not yet produced.
module lzss_rle_stream_decoder #(
	parameter int WINDOW_DEPTH = 8192
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lrsd_in_if.sink    in_ch,
	lrsd_out_if.source out_ch
);
	import lrsd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	lrsd_tick_t    tick;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          adv;
	logic          go;

	// One parser step happens per accepted beat.
	assign in_ch.ready = adv;
	assign go          = in_ch.valid && adv;

	lrsd_parse #(.WINDOW_DEPTH(WINDOW_DEPTH), .AW(AW)) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.in_valid (in_ch.in_valid),
		.in_byte  (in_ch.in_byte),
		.in_last  (in_ch.in_last),
		.tick     (tick),
		.waddr    (waddr),
		.raddr    (raddr)
	);

	lrsd_hist #(.WINDOW_DEPTH(WINDOW_DEPTH), .AW(AW)) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.tick   (tick),
		.waddr  (waddr),
		.raddr  (raddr),
		.adv    (adv),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire

// ----- bench/lzss_rle_stream_decoder_test.sv -----
`timescale 1ns / 1ps
module lzss_rle_stream_decoder_test;
	import lrsd_pkg::*;

	localparam int HIST_DEPTH  = 8192;
	localparam int CYCLE_LIMIT = 2000000;

	// Parser phases of the decoder as the predictor tracks them.
	typedef enum int {
		S_HDR_LO, S_HDR_HI, S_HDR_FMT, S_CTL_BYTE, S_PAD,
		S_BTOK, S_BAFTER, S_BLITLEN, S_LIT, S_BRUNLEN, S_BFILL, S_BOFF,
		S_BSIZE_LO, S_BSIZE_HI,
		S_KIND, S_MATCH_KIND, S_OFF_SHORT, S_OFF_HI, S_OFF_LO, S_RUN_KIND,
		S_RUN_LEN, S_RUN_LEN_LO, S_RUN_FILL, S_CHAIN, S_LEN, S_LEN_BYTE, S_LEN_BITS,
		S_FILL, S_COPY, S_DONE, S_BAD
	} dec_phase_t;

	// What one beat on the result side is expected to carry.
	typedef struct {
		bit       taken;
		bit       ov;
		bit [7:0] ob;
		bit [1:0] st;
	} tick_res_t;

	logic clk = 1'b0;
	logic arst_n;

	lrsd_in_if  in_ch ();
	lrsd_out_if out_ch ();

	lzss_rle_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: a private copy of everything the decoder keeps.
	bit [7:0]    hist [0:HIST_DEPTH-1];
	int unsigned wr_ptr, produced, pend, copy_off, blk_left, bit_cnt, flags;
	bit          byte_fmt, half_word, long_run, drained;
	bit [15:0]   flag_bits;
	bit [7:0]    fill;
	dec_phase_t  ph;

	// Expected result beats, oldest first.
	tick_res_t expected_q [$];

	// Compressed stream under construction and the sender's position in it.
	bit [7:0]    comp_q [$];
	bit [7:0]    blk_q [$];
	int          send_idx;
	int          last_idx;
	int unsigned gen_produced;
	int          ctl_pos, ctl_left, ctl_bit;

	int  errors = 0;
	int  beats;
	int  decoded = 0;
	int  cycles = 0;
	int  stall_left;
	bit  quiet;
	tick_res_t got;

	task report(input string msg);
		if (errors < 40)
			$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	task reset_decoder();
		wr_ptr = 0; produced = 0; byte_fmt = 0; ph = S_HDR_LO;
		flag_bits = 0; flags = 0; pend = 0; copy_off = 0; fill = 0; blk_left = 0;
		half_word = 0; bit_cnt = 0; long_run = 0; drained = 0;
	endtask

	function bit is_bit_phase(input dec_phase_t p);
		return p == S_KIND || p == S_MATCH_KIND || p == S_OFF_HI ||
			p == S_RUN_KIND || p == S_RUN_LEN || p == S_LEN || p == S_LEN_BITS;
	endfunction

	function bit decoder_halted();
		return ph == S_DONE || ph == S_BAD;
	endfunction

	// Every decoded byte also lands in the history ring.
	task hist_push(input bit [7:0] v);
		hist[wr_ptr] = v;
		wr_ptr = (wr_ptr + 1 >= HIST_DEPTH) ? 0 : wr_ptr + 1;
		if (produced < HIST_DEPTH)
			produced++;
	endtask

	task match_ready();
		ph = (copy_off > produced) ? S_BAD : S_COPY;
	endtask

	// Byte-coded token opcode: literal run, fill run or copy.
	task decode_ctl(input bit [7:0] b);
		if (!b[7]) begin
			if (!b[6]) begin
				pend = b & 8'h1F;
				if (b[5])
					ph = S_BLITLEN;
				else
					ph = (pend != 0) ? S_LIT : S_BAD;
			end else begin
				pend = b & 8'h2F;
				if (b[4]) begin
					ph = S_BRUNLEN;
				end else begin
					pend += 4;
					ph = S_BFILL;
				end
			end
		end else begin
			pend = ((b & 8'h60) >> 5) + 4;
			copy_off = (b & 8'h1F) << 8;
			ph = S_BOFF;
		end
	endtask

	// At a block boundary the byte is either the end marker or a chain marker.
	task block_token(input bit [7:0] b);
		if (blk_left == 0) begin
			ph = (b == 0) ? S_DONE : S_BSIZE_LO;
		end else begin
			blk_left--;
			decode_ctl(b);
		end
	endtask

	task open_block();
		if (blk_left < 2) begin
			ph = S_BAD;
		end else begin
			blk_left -= 2;
			ph = S_BTOK;
		end
	endtask

	task bit_step(input bit b);
		case (ph)
			S_KIND: begin
				if (b) begin
					ph = S_MATCH_KIND;
				end else begin
					pend = 1;
					ph = S_LIT;
				end
			end
			S_MATCH_KIND: begin
				if (b) begin
					copy_off = 0;
					bit_cnt = 5;
					ph = S_OFF_HI;
				end else begin
					ph = S_OFF_SHORT;
				end
			end
			S_OFF_HI: begin
				copy_off = ((copy_off << 1) | b) & 32'h1F;
				bit_cnt--;
				if (bit_cnt == 0)
					ph = S_OFF_LO;
			end
			S_RUN_KIND: begin
				long_run = b;
				pend = 0;
				bit_cnt = 4;
				ph = S_RUN_LEN;
			end
			S_RUN_LEN: begin
				pend = ((pend << 1) | b) & 32'hF;
				bit_cnt--;
				if (bit_cnt == 0) begin
					if (long_run) begin
						ph = S_RUN_LEN_LO;
					end else begin
						pend += 14;
						ph = S_RUN_FILL;
					end
				end
			end
			S_LEN: begin
				// Unary prefix for lengths two to five, then a 3-bit or an 8-bit tail.
				if (pend >= 6) begin
					if (b) begin
						pend = 0;
						bit_cnt = 3;
						ph = S_LEN_BITS;
					end else begin
						ph = S_LEN_BYTE;
					end
				end else if (b) begin
					match_ready();
				end else begin
					pend++;
				end
			end
			S_LEN_BITS: begin
				pend = ((pend << 1) | b) & 32'h7;
				bit_cnt--;
				if (bit_cnt == 0) begin
					pend += 6;
					match_ready();
				end
			end
			default: ;
		endcase
	endtask

	task byte_step(input bit [7:0] b, output bit ov, output bit [7:0] ob);
		ov = 0;
		ob = 0;
		case (ph)
			S_HDR_LO: begin blk_left = b; ph = S_HDR_HI; end
			S_HDR_HI: begin blk_left |= b << 8; ph = S_HDR_FMT; end
			S_HDR_FMT: begin
				// A nonzero format byte doubles as the first token.
				if (b == 0) begin
					byte_fmt = 0;
					ph = S_CTL_BYTE;
				end else begin
					byte_fmt = 1;
					open_block();
					if (ph == S_BTOK)
						block_token(b);
				end
			end
			S_CTL_BYTE: begin
				flag_bits = b;
				flags = 8;
				half_word = 0;
				ph = S_KIND;
			end
			S_PAD: begin
				if (pend > 0)
					pend--;
				if (pend == 0)
					ph = S_CTL_BYTE;
			end
			S_BTOK: block_token(b);
			S_BAFTER: begin
				// A copy may be extended by continuation tokens.
				if (blk_left != 0 && (b & 8'hE0) == 8'h60) begin
					blk_left--;
					pend = b & 8'h1F;
					ph = (pend != 0) ? S_COPY : S_BAFTER;
				end else begin
					block_token(b);
				end
			end
			S_BLITLEN: begin
				blk_left--;
				pend = (pend << 8) | b;
				ph = (pend != 0) ? S_LIT : S_BAD;
			end
			S_LIT: begin
				if (byte_fmt)
					blk_left--;
				ov = 1;
				ob = b;
				hist_push(b);
				if (pend > 0)
					pend--;
				if (pend == 0)
					ph = byte_fmt ? S_BTOK : S_KIND;
			end
			S_BRUNLEN: begin
				blk_left--;
				pend = ((pend << 8) | b) + 4;
				ph = S_BFILL;
			end
			S_BFILL, S_RUN_FILL: begin
				if (ph == S_BFILL)
					blk_left--;
				fill = b;
				ph = S_FILL;
			end
			S_BOFF: begin
				blk_left--;
				copy_off |= b;
				ph = (copy_off == 0 || copy_off > produced) ? S_BAD : S_COPY;
			end
			S_BSIZE_LO: begin blk_left = b; ph = S_BSIZE_HI; end
			S_BSIZE_HI: begin blk_left |= b << 8; open_block(); end
			S_OFF_SHORT: begin
				if (b == 0) begin
					ph = S_BAD;
				end else begin
					copy_off = b;
					pend = 2;
					ph = S_LEN;
				end
			end
			S_OFF_LO: begin
				// Long offset 1 opens a fill run, 0 a block marker.
				copy_off = ((copy_off << 8) | b) & 32'h1FFF;
				if (copy_off > 1) begin
					pend = 2;
					ph = S_LEN;
				end else begin
					ph = (copy_off != 0) ? S_RUN_KIND : S_CHAIN;
				end
			end
			S_RUN_LEN_LO: begin
				pend = ((pend << 8) | b) + 14;
				ph = S_RUN_FILL;
			end
			S_LEN_BYTE: begin
				pend = b + 14;
				match_ready();
			end
			S_CHAIN: begin
				if (b == 0) begin
					ph = S_DONE;
				end else begin
					pend = 3;
					ph = S_PAD;
				end
			end
			default: ;
		endcase
	endtask

	// One decoder tick: the offered byte in, the expected result beat out.
	task advance_decoder(input bit v, input bit [7:0] b, input bit l, output tick_res_t r);
		dec_phase_t p;
		bit         body, marker, fbit;
		bit [7:0]   val;
		p = ph;
		body = p == S_BLITLEN || p == S_BRUNLEN || p == S_BFILL || p == S_BOFF ||
			(p == S_LIT && byte_fmt);
		marker = (p == S_BTOK || p == S_BAFTER) && blk_left == 0;
		r.taken = 0;
		r.ov = 0;
		r.ob = 0;
		if (p == S_FILL || p == S_COPY) begin
			// Emitting a copied or filled byte takes no input.
			if (pend > 0) begin
				val = fill;
				if (p == S_COPY)
					val = hist[(wr_ptr + HIST_DEPTH - (copy_off % HIST_DEPTH)) % HIST_DEPTH];
				r.ov = 1;
				r.ob = val;
				hist_push(val);
				pend--;
			end
			if (pend == 0) begin
				if (!byte_fmt)
					ph = S_KIND;
				else
					ph = (p == S_COPY) ? S_BAFTER : S_BTOK;
			end
		end else if (p == S_DONE || p == S_BAD) begin
		end else if (is_bit_phase(p) && flags != 0) begin
			fbit = flag_bits[0];
			flag_bits >>= 1;
			flags--;
			bit_step(fbit);
		end else if (marker && drained) begin
			ph = S_DONE;
		end else if (body && blk_left == 0) begin
			ph = S_BAD;
		end else if (drained) begin
			ph = S_BAD;
		end else if (v) begin
			r.taken = 1;
			if (l)
				drained = 1;
			if (is_bit_phase(p)) begin
				// Control words arrive low byte first.
				if (!half_word) begin
					flag_bits = b;
					half_word = 1;
				end else begin
					flag_bits = flag_bits | (16'(b) << 8);
					flags = 16;
					half_word = 0;
				end
			end else begin
				byte_step(b, r.ov, r.ob);
			end
		end
		r.st = (ph == S_DONE) ? ST_DONE : (ph == S_BAD) ? ST_BAD : ST_RUN;
	endtask

	// ---------------------------------------------------------------------
	// Stream builders
	// ---------------------------------------------------------------------

	function int unsigned copy_reach();
		return (gen_produced < 8191) ? gen_produced : 8191;
	endfunction

	task note_output(input int unsigned n);
		gen_produced = (gen_produced + n > HIST_DEPTH) ? HIST_DEPTH : gen_produced + n;
	endtask

	// Control bits are reserved in the stream exactly when the decoder asks.
	task put_bit(input bit b);
		if (ctl_left == 0) begin
			ctl_pos = comp_q.size();
			comp_q.push_back(8'h00);
			comp_q.push_back(8'h00);
			ctl_left = 16;
			ctl_bit = 0;
		end
		comp_q[ctl_pos + ctl_bit / 8] = comp_q[ctl_pos + ctl_bit / 8] | (8'(b) << (ctl_bit % 8));
		ctl_bit++;
		ctl_left--;
	endtask

	task put_bits(input int unsigned v, input int n);
		for (int i = n - 1; i >= 0; i--)
			put_bit(v[i]);
	endtask

	task open_ctl_byte();
		ctl_pos = comp_q.size();
		comp_q.push_back(8'h00);
		ctl_left = 8;
		ctl_bit = 0;
	endtask

	task put_len(input int unsigned n);
		if (n <= 5) begin
			put_bits(0, n - 2);
			put_bit(1);
		end else if (n <= 13) begin
			put_bits(0, 4);
			put_bit(1);
			put_bits(n - 6, 3);
		end else begin
			put_bits(0, 5);
			comp_q.push_back(8'(n - 14));
		end
	endtask

	task bit_literal(input bit [7:0] b);
		put_bit(0);
		comp_q.push_back(b);
		note_output(1);
	endtask

	task bit_copy(input bit far, input int unsigned d, input int unsigned n);
		put_bit(1);
		if (!far) begin
			put_bit(0);
			comp_q.push_back(8'(d));
		end else begin
			put_bit(1);
			put_bits(d >> 8, 5);
			comp_q.push_back(8'(d));
		end
		put_len(n);
		note_output(n);
	endtask

	task bit_run(input bit lng, input int unsigned k, input bit [7:0] lo);
		put_bit(1);
		put_bit(1);
		put_bits(0, 5);
		comp_q.push_back(8'h01);
		put_bit(lng);
		put_bits(k, 4);
		if (lng)
			comp_q.push_back(lo);
		comp_q.push_back(8'($urandom));
		note_output(lng ? ((k << 8) | lo) + 14 : k + 14);
	endtask

	// A long offset of zero is a block marker: zero ends, nonzero chains.
	task bit_marker(input bit [7:0] m);
		put_bit(1);
		put_bit(1);
		put_bits(0, 5);
		comp_q.push_back(8'h00);
		comp_q.push_back(m);
	endtask

	function int unsigned rand_match_len();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(2, 5);
		if (r < 9)
			return $urandom_range(6, 13);
		return $urandom_range(14, 269);
	endfunction

	task bit_random_token();
		int unsigned kind;
		kind = $urandom_range(0, 24);
		if (kind < 8 || gen_produced < 2) begin
			bit_literal(8'($urandom));
		end else if (kind < 14) begin
			bit_copy(0, $urandom_range(1, (copy_reach() < 255) ? copy_reach() : 255),
				rand_match_len());
		end else if (kind < 19) begin
			bit_copy(1, $urandom_range(2, copy_reach()), rand_match_len());
		end else if (kind < 22) begin
			bit_run(0, $urandom_range(0, 15), 8'h00);
		end else if (kind < 24) begin
			bit_run(1, 0, 8'($urandom));
		end else begin
			bit_marker(8'($urandom_range(1, 255)));
			repeat (3) comp_q.push_back(8'($urandom));
			open_ctl_byte();
		end
	endtask

	task byte_literal(input int unsigned n);
		if (n < 32)
			blk_q.push_back(8'(n));
		else begin
			blk_q.push_back(8'h20 | 8'(n >> 8));
			blk_q.push_back(8'(n));
		end
		repeat (n) blk_q.push_back(8'($urandom));
		note_output(n);
	endtask

	task byte_copy(input int unsigned sel, input int unsigned d, input int conts);
		int unsigned c;
		blk_q.push_back(8'h80 | 8'(sel << 5) | 8'(d >> 8));
		blk_q.push_back(8'(d));
		note_output(sel + 4);
		repeat (conts) begin
			c = $urandom_range(0, 31);
			blk_q.push_back(8'h60 | 8'(c));
			note_output(c);
		end
	endtask

	// Fill runs: 0x40..0x4F carry the length, 0x50..0x5F take a length byte.
	task byte_run(input bit [7:0] op, input bit [7:0] lo);
		blk_q.push_back(op);
		if (op[4]) begin
			blk_q.push_back(lo);
			note_output((((op & 8'h0F) << 8) | lo) + 4);
		end else begin
			note_output((op & 8'h0F) + 4);
		end
		blk_q.push_back(8'($urandom));
	endtask

	task byte_random_token();
		int unsigned kind;
		kind = $urandom_range(0, 19);
		if (kind < 5 || gen_produced == 0)
			byte_literal($urandom_range(1, 31));
		else if (kind < 7)
			byte_literal($urandom_range(1, 300));
		else if (kind < 10)
			byte_run(8'h40 | 8'($urandom_range(0, 15)), 8'h00);
		else if (kind < 12)
			byte_run(8'h50, 8'($urandom));
		else
			byte_copy($urandom_range(0, 3), $urandom_range(1, copy_reach()),
				($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
	endtask

	// Size bytes count themselves; later blocks open with a chain marker.
	task close_block(input bit first);
		int unsigned sz;
		if (!first)
			comp_q.push_back(8'($urandom_range(1, 255)));
		sz = blk_q.size() + 2;
		comp_q.push_back(8'(sz));
		comp_q.push_back(8'(sz >> 8));
		foreach (blk_q[i])
			comp_q.push_back(blk_q[i]);
		blk_q.delete();
	endtask

	// ---------------------------------------------------------------------
	// Sender, pacing and checking
	// ---------------------------------------------------------------------

	task send_tick(input bit v, input bit [7:0] b, input bit l, output bit taken);
		tick_res_t e;
		in_ch.valid    <= 1'b1;
		in_ch.in_valid <= v;
		in_ch.in_byte  <= b;
		in_ch.in_last  <= l;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		advance_decoder(v, b, l, e);
		expected_q.push_back(e);
		taken = e.taken;
		beats++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Offer stream bytes up to lim, re-offering each until the decoder takes it.
	task pump(input int lim);
		bit t;
		while (send_idx < lim && !decoder_halted()) begin
			if ($urandom_range(0, 9) == 0) begin
				send_tick(1'b0, 8'($urandom), 1'($urandom), t);
			end else begin
				send_tick(1'b1, comp_q[send_idx], send_idx == last_idx, t);
				if (t)
					send_idx++;
			end
		end
	endtask

	// A bit-format control word may still be filling; hold back from it.
	task pump_ready();
		if (!byte_fmt && ctl_left > 0)
			pump(ctl_pos);
		else
			pump(comp_q.size());
	endtask

	task hold_until_drained();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (quiet) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 11);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Every result beat is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				got = expected_q.pop_front();
				if (out_ch.byte_taken !== got.taken)
					report($sformatf("byte_taken %b, expected %b", out_ch.byte_taken, got.taken));
				if (out_ch.out_valid !== got.ov)
					report($sformatf("out_valid %b, expected %b", out_ch.out_valid, got.ov));
				if (out_ch.out_byte !== got.ob)
					report($sformatf("out_byte %h, expected %h", out_ch.out_byte, got.ob));
				if (out_ch.status !== got.st)
					report($sformatf("status %0d, expected %0d", out_ch.status, got.st));
				if (got.ov)
					decoded++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// The header picks the format; a few hand-made tokens then cover the
	// field extremes and the corner cases of each token kind.
	task test_header_and_directed();
		byte_fmt_choice: begin end
		if ($urandom_range(0, 1)) begin
			blk_q.push_back(8'h01); blk_q.push_back(8'h00);
			blk_q.push_back(8'h03); blk_q.push_back(8'hFF);
			blk_q.push_back(8'h55); blk_q.push_back(8'hAA);
			note_output(4);
			// Distance one repeats the last byte; a zero continuation copies nothing.
			byte_copy(0, 1, 0);
			blk_q.push_back(8'h60);
			blk_q.push_back(8'h62);
			note_output(2);
			byte_copy(3, 4, 0);
			byte_run(8'h4F, 8'h00);
			byte_literal(258);
			close_block(1);
		end else begin
			comp_q.push_back(8'($urandom));
			comp_q.push_back(8'($urandom));
			comp_q.push_back(8'h00);
			open_ctl_byte();
			bit_literal(8'h00);
			bit_literal(8'hFF);
			bit_copy(0, 1, 2);
			bit_copy(0, 2, 5);
			bit_copy(1, 3, 6);
			bit_copy(1, 2, 13);
			bit_run(0, 0, 8'h00);
			bit_copy(1, 8, 14);
			bit_copy(0, 4, 269);
		end
		pump_ready();
	endtask

	// Random tokens until the run has sent about budget beats in total.
	task test_random_tokens(input int budget);
		while (beats < budget && !decoder_halted()) begin
			if (byte_fmt) begin
				repeat ($urandom_range(0, 3)) byte_random_token();
				close_block(0);
			end else begin
				repeat ($urandom_range(1, 3)) bit_random_token();
			end
			pump_ready();
		end
	endtask

	// The stream ends cleanly, at a drained boundary, or broken.
	task test_stream_tail();
		int unsigned how;
		quiet = 1;
		how = $urandom_range(0, 4);
		if (byte_fmt) begin
			case (how)
				0: comp_q.push_back(8'h00);
				1: ;
				2: begin
					byte_random_token();
					if ($urandom_range(0, 1))
						blk_q.push_back(8'h00);
					else begin
						blk_q.push_back(8'h80);
						blk_q.push_back(8'h00);
					end
					close_block(0);
				end
				3: begin
					// A copy opcode whose offset byte lies beyond the block.
					blk_q.push_back(8'h81);
					close_block(0);
					comp_q.push_back(8'h01);
				end
				default: begin
					byte_literal(12);
					close_block(0);
					last_idx = comp_q.size() - 6;
				end
			endcase
		end else begin
			case (how)
				0, 1: bit_marker(8'h00);
				2: begin
					put_bit(1);
					put_bit(0);
					comp_q.push_back(8'h00);
				end
				3: begin
					if (gen_produced < 8191)
						bit_copy(1, 8191, 2);
					else
						bit_copy(0, 0, 2);
				end
				default: begin
					repeat (6) bit_literal(8'($urandom));
					last_idx = comp_q.size() - 3;
				end
			endcase
		end
		if (last_idx < 0)
			last_idx = comp_q.size() - 1;
		pump(comp_q.size());
	endtask

	// Once the stream is over the decoder must settle and then stay put.
	task test_terminal_hold();
		bit t;
		int guard;
		guard = 0;
		while (!decoder_halted() && guard < 20000) begin
			send_tick(1'($urandom), 8'($urandom), 1'($urandom), t);
			guard++;
		end
		repeat (20) send_tick(1'($urandom), 8'($urandom), 1'($urandom), t);
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_ch.valid    <= 1'b0;
		in_ch.in_valid <= 1'b0;
		in_ch.in_byte  <= 8'h00;
		in_ch.in_last  <= 1'b0;
		beats = 0; quiet = 0;
		send_idx = 0; last_idx = -1; gen_produced = 0; ctl_left = 0; ctl_pos = 0;
		reset_decoder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_and_directed();
		test_random_tokens(450);
		// Let every result drain before the decoder is fed again.
		hold_until_drained();
		test_random_tokens(580);
		test_stream_tail();
		test_terminal_hold();

		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%s stream: %0d beats, %0d decoded bytes checked, final status %0d",
			byte_fmt ? "byte-coded" : "bit-flag", beats, decoded, ph == S_DONE ? 1 : 2);
		$display("mixed tokens, a full drain pause and a stream tail ran, %0d mismatches",
			errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
